@@ hdl/hsl2rgb_pkg.sv @@
// Shared constants and helpers for the HSL to RGB converter.
package hsl2rgb_pkg;

  localparam int DEF_FRAC_BITS   = 16;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam int HUE_W        = 9;
  localparam int ANG_W        = HUE_W + 1;
  localparam int FRAC_IN_W    = 17;
  localparam int IN_FRAC_BITS = 16;
  localparam int CH_W         = 8;
  localparam int WEIGHT_W     = 7;

  localparam logic [FRAC_IN_W-1:0] IN_ONE = 17'h10000;

  localparam logic [ANG_W-1:0] HUE_TURN       = 10'd360;
  localparam logic [ANG_W-1:0] HUE_THIRD      = 10'd120;
  localparam logic [ANG_W-1:0] HUE_TWO_THIRDS = 10'd240;
  localparam logic [ANG_W-1:0] SEG_RISE_END   = 10'd60;
  localparam logic [ANG_W-1:0] SEG_HOLD_END   = 10'd180;
  localparam logic [ANG_W-1:0] SEG_FALL_END   = 10'd240;

  localparam logic [WEIGHT_W-1:0] RAMP_SPAN = 7'd60;

  // 255/60 reduces to 17/4: scale by 17, then drop two extra bits
  localparam logic [4:0] SCALE_MUL   = 5'd17;
  localparam int         SCALE_SHIFT = 2;

  localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

  // packed item between front and back: l, s, l*s, three weights, alpha
  function automatic int item_width(input int frac_bits);
    return 3 * (frac_bits + 1) + 3 * WEIGHT_W + CH_W;
  endfunction

  // weight of (m2 - m1) in the ramp for a wrapped angle: ramp = 60*m1 + diff*w
  function automatic logic [WEIGHT_W-1:0] ramp_weight(input logic [ANG_W-1:0] ang);
    logic [ANG_W-1:0] fall;
    fall = SEG_FALL_END - ang;
    if (ang < SEG_RISE_END) begin
      return ang[WEIGHT_W-1:0];
    end else if (ang < SEG_HOLD_END) begin
      return RAMP_SPAN;
    end else if (ang < SEG_FALL_END) begin
      return fall[WEIGHT_W-1:0];
    end else begin
      return '0;
    end
  endfunction

endpackage

@@ hdl/hsl2rgb_front.sv @@
// Front end: accepts pixels, wraps hue into ramp weights, forms l*s.
module hsl2rgb_front import hsl2rgb_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               hsl_valid,
  output logic                               hsl_ready,
  input  logic [HUE_W-1:0]                   hue_deg,
  input  logic [FRAC_IN_W-1:0]               saturation,
  input  logic [FRAC_IN_W-1:0]               lightness,
  input  logic [CH_W-1:0]                    alpha_in,
  output logic                               item_valid,
  input  logic                               item_ready,
  output logic [item_width(FRAC_BITS)-1:0]   item_data
);

  localparam int W = FRAC_BITS + 1;

  logic [FRAC_IN_W-1:0] sat_s;
  logic [FRAC_IN_W-1:0] sat_l;
  logic [W-1:0]         s_int;
  logic [W-1:0]         l_int;
  logic [ANG_W-1:0]     hue_ext;
  logic [ANG_W-1:0]     hue_w;
  logic [ANG_W-1:0]     ang_r_raw;
  logic [ANG_W-1:0]     ang_b_raw;
  logic [ANG_W-1:0]     ang_r;
  logic [ANG_W-1:0]     ang_b;

  logic                 f1_valid;
  logic [W-1:0]         f1_s;
  logic [W-1:0]         f1_l;
  logic [WEIGHT_W-1:0]  f1_wr;
  logic [WEIGHT_W-1:0]  f1_wg;
  logic [WEIGHT_W-1:0]  f1_wb;
  logic [CH_W-1:0]      f1_alpha;

  logic                 f2_valid;
  logic [W-1:0]         f2_s;
  logic [W-1:0]         f2_l;
  logic [W-1:0]         f2_ls;
  logic [WEIGHT_W-1:0]  f2_wr;
  logic [WEIGHT_W-1:0]  f2_wg;
  logic [WEIGHT_W-1:0]  f2_wb;
  logic [CH_W-1:0]      f2_alpha;

  logic [2*W-1:0]       prod;
  logic                 f1_en;
  logic                 f2_en;

  // saturate to 1.0, then rescale to the internal fraction width
  assign sat_s = (saturation > IN_ONE) ? IN_ONE : saturation;
  assign sat_l = (lightness > IN_ONE) ? IN_ONE : lightness;

  if (FRAC_BITS >= IN_FRAC_BITS) begin : g_scale_up
    assign s_int = W'(sat_s) << (FRAC_BITS - IN_FRAC_BITS);
    assign l_int = W'(sat_l) << (FRAC_BITS - IN_FRAC_BITS);
  end else begin : g_scale_down
    assign s_int = W'(sat_s >> (IN_FRAC_BITS - FRAC_BITS));
    assign l_int = W'(sat_l >> (IN_FRAC_BITS - FRAC_BITS));
  end

  // hue wrap and the two shifted angles
  assign hue_ext   = {1'b0, hue_deg};
  assign hue_w     = (hue_ext >= HUE_TURN) ? hue_ext - HUE_TURN : hue_ext;
  assign ang_r_raw = hue_w + HUE_THIRD;
  assign ang_b_raw = hue_w + HUE_TWO_THIRDS;
  assign ang_r     = (ang_r_raw >= HUE_TURN) ? ang_r_raw - HUE_TURN : ang_r_raw;
  assign ang_b     = (ang_b_raw >= HUE_TURN) ? ang_b_raw - HUE_TURN : ang_b_raw;

  assign f2_en     = !f2_valid || item_ready;
  assign f1_en     = !f1_valid || f2_en;
  assign hsl_ready = f1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (f1_en) begin
      f1_valid <= hsl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_en) begin
      f1_s     <= s_int;
      f1_l     <= l_int;
      f1_wr    <= ramp_weight(ang_r);
      f1_wg    <= ramp_weight(hue_w);
      f1_wb    <= ramp_weight(ang_b);
      f1_alpha <= alpha_in;
    end
  end

  assign prod = f1_l * f1_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (f2_en) begin
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f2_en) begin
      f2_s     <= f1_s;
      f2_l     <= f1_l;
      f2_ls    <= prod[FRAC_BITS +: W];
      f2_wr    <= f1_wr;
      f2_wg    <= f1_wg;
      f2_wb    <= f1_wb;
      f2_alpha <= f1_alpha;
    end
  end

  assign item_valid = f2_valid;
  assign item_data  = {f2_l, f2_s, f2_ls, f2_wr, f2_wg, f2_wb, f2_alpha};

endmodule

@@ hdl/hsl2rgb_queue.sv @@
// Small register queue decoupling the front and back ends.
module hsl2rgb_queue import hsl2rgb_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH,
  parameter int WIDTH = item_width(DEF_FRAC_BITS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not grow on push");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not shrink on pop");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with pointers apart");

endmodule

@@ hdl/hsl2rgb_back.sv @@
// Back end: m1/m2, three ramp evaluations, scale by 255 and clamp.
module hsl2rgb_back import hsl2rgb_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  logic [item_width(FRAC_BITS)-1:0] item_data,
  output logic                             rgb_valid,
  input  logic                             rgb_ready,
  output logic [CH_W-1:0]                  red,
  output logic [CH_W-1:0]                  green,
  output logic [CH_W-1:0]                  blue,
  output logic [CH_W-1:0]                  alpha_out
);

  localparam int W     = FRAC_BITS + 1;
  localparam int RW    = FRAC_BITS + 7;           // ramp <= 60 * ONE
  localparam int SW    = RW + 5;                  // ramp * 17
  localparam int LO    = FRAC_BITS + SCALE_SHIFT;
  localparam int CWIDE = SW - LO;
  localparam logic [W-1:0] HALF = W'(1) << (FRAC_BITS - 1);

  logic [W-1:0]        q_l;
  logic [W-1:0]        q_s;
  logic [W-1:0]        q_ls;
  logic [WEIGHT_W-1:0] q_w [3];
  logic [CH_W-1:0]     q_alpha;

  logic [W:0]          m2_wide;
  logic [W:0]          m1_wide;
  logic [W-1:0]        m2_cur;
  logic [W-1:0]        m1_cur;

  logic                b1_valid;
  logic [W-1:0]        b1_m1;
  logic [W-1:0]        b1_diff;
  logic [WEIGHT_W-1:0] b1_w [3];
  logic [CH_W-1:0]     b1_alpha;

  logic                b2_valid;
  logic [RW-1:0]       b2_ramp [3];
  logic [CH_W-1:0]     b2_alpha;

  logic [SW-1:0]       scaled [3];
  logic [CWIDE-1:0]    ch_wide [3];
  logic [CH_W-1:0]     ch_sat [3];
  logic [CH_W-1:0]     chan [3];

  logic                out_en;
  logic                b2_en;
  logic                b1_en;

  assign {q_l, q_s, q_ls, q_w[0], q_w[1], q_w[2], q_alpha} = item_data;

  assign m2_wide = (q_l <= HALF) ? {1'b0, q_l} + {1'b0, q_ls}
                                 : {1'b0, q_l} + {1'b0, q_s} - {1'b0, q_ls};
  assign m1_wide = {q_l, 1'b0} - m2_wide;
  assign m2_cur  = m2_wide[W-1:0];
  assign m1_cur  = m1_wide[W-1:0];

  assign out_en     = !rgb_valid || rgb_ready;
  assign b2_en      = !b2_valid || out_en;
  assign b1_en      = !b1_valid || b2_en;
  assign item_ready = b1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      rgb_valid <= 1'b0;
    end else begin
      if (b1_en) begin
        b1_valid <= item_valid;
      end
      if (b2_en) begin
        b2_valid <= b1_valid;
      end
      if (out_en) begin
        rgb_valid <= b2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b1_en) begin
      b1_m1    <= m1_cur;
      b1_diff  <= m2_cur - m1_cur;
      b1_w     <= q_w;
      b1_alpha <= q_alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (b2_en) begin
      for (int i = 0; i < 3; i++) begin
        b2_ramp[i] <= RW'(b1_m1) * RW'(RAMP_SPAN) + RW'(b1_diff) * RW'(b1_w[i]);
      end
      b2_alpha <= b1_alpha;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      scaled[i]  = SW'(b2_ramp[i]) * SW'(SCALE_MUL);
      ch_wide[i] = scaled[i][SW-1:LO];
      ch_sat[i]  = (ch_wide[i] > CWIDE'(CH_MAX)) ? CH_MAX : ch_wide[i][CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      chan      <= ch_sat;
      alpha_out <= b2_alpha;
    end
  end

  assign red   = chan[0];
  assign green = chan[1];
  assign blue  = chan[2];

endmodule

@@ hdl/hsl_to_rgb_converter_unit.sv @@
// Top level of the HSL to RGB pixel converter.
//
// Input channel (hsl_valid/hsl_ready): one pixel per transaction, hue in
// whole degrees (values 360..511 wrap), saturation and lightness with
// 65536 = 1.0 (larger values clip to 1.0), and an alpha byte.
// Output channel (rgb_valid/rgb_ready): one transaction per pixel, red,
// green and blue truncated and clamped to 0..255, alpha copied through.
//
// Throughput: one pixel per clock sustained while rgb_ready stays high.
// Each pixel passes two front stages, the queue write and two back
// stages feeding the output register, in that order.
// The front end (hue wrap, ramp weights, l*s multiply) and back end
// (m1/m2, three ramp multipliers, scale by 255/60 = 17/4, clamp) are
// split by a QUEUE_DEPTH entry queue; each side stalls on its own.
// When rgb_ready is low the output register holds its transaction, the
// back end fills, then the queue, then the front end; hsl_ready drops
// only once the front stages are full.
// Reset (rst, synchronous) empties all stages and the queue; no state
// survives between pixels.
module hsl_to_rgb_converter_unit import hsl2rgb_pkg::*; #(
  parameter int FRAC_BITS   = DEF_FRAC_BITS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 hsl_valid,
  output logic                 hsl_ready,
  input  logic [HUE_W-1:0]     hue_deg,
  input  logic [FRAC_IN_W-1:0] saturation,
  input  logic [FRAC_IN_W-1:0] lightness,
  input  logic [CH_W-1:0]      alpha_in,
  output logic                 rgb_valid,
  input  logic                 rgb_ready,
  output logic [CH_W-1:0]      red,
  output logic [CH_W-1:0]      green,
  output logic [CH_W-1:0]      blue,
  output logic [CH_W-1:0]      alpha_out
);

  localparam int ITEM_W = item_width(FRAC_BITS);

  // front end -> queue
  logic              fq_valid;
  logic              fq_ready;
  logic [ITEM_W-1:0] fq_data;

  // queue -> back end
  logic              qb_valid;
  logic              qb_ready;
  logic [ITEM_W-1:0] qb_data;

  hsl2rgb_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .hsl_valid  (hsl_valid),
    .hsl_ready  (hsl_ready),
    .hue_deg    (hue_deg),
    .saturation (saturation),
    .lightness  (lightness),
    .alpha_in   (alpha_in),
    .item_valid (fq_valid),
    .item_ready (fq_ready),
    .item_data  (fq_data)
  );

  hsl2rgb_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ITEM_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  hsl2rgb_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (qb_valid),
    .item_ready (qb_ready),
    .item_data  (qb_data),
    .rgb_valid  (rgb_valid),
    .rgb_ready  (rgb_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha_out  (alpha_out)
  );

endmodule
